@@ hdl/fbsp_pkg.sv @@
// Shared types and constants for the framed byte stream parser.
// Used by fbsp_ctrl, fbsp_dp and framed_byte_stream_parser.
`timescale 1ns / 1ps

package fbsp_pkg;

  // Framing bytes
  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE  = 8'h55;

  // Field widths fixed by the interface
  localparam int BYTE_W = 8;
  localparam int POS_W  = 5;
  localparam int FLEN_W = 6;

  // Default largest payload length
  localparam int PAYLOAD_MAX_DEF = 32;

  // Controller states: five parse phases, then a two-step drain per byte
  typedef enum logic [2:0] {
    S_HEAD     = 3'd0,
    S_LEN      = 3'd1,
    S_DATA     = 3'd2,
    S_SUM      = 3'd3,
    S_END      = 3'd4,
    S_DRAIN_RD = 3'd5,
    S_DRAIN_LD = 3'd6
  } fbsp_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr;          // clear length, count and checksum
    logic load_len;     // take the byte as the declared length
    logic store_byte;   // write a payload byte and fold it into the checksum
    logic drain_start;  // rewind the count for the output run
    logic rd_issue;     // read the store at the current count
    logic out_load;     // move read data into the output register
  } fbsp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_head;      // received byte is the head byte
    logic is_end;       // received byte is the end byte
    logic len_ok;       // received byte is a legal length
    logic sum_ok;       // received byte matches the running checksum
    logic data_done;    // this payload byte completes the frame payload
    logic drain_last;   // byte being loaded is the final one
    logic out_free;     // output register can take a byte this cycle
  } fbsp_sts_t;

endpackage

@@ hdl/fbsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fbsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/fbsp_ctrl.sv @@
// Controller state machine of the framed byte stream parser.
// Depends on fbsp_pkg; drives fbsp_dp through fbsp_cmd_t and reads fbsp_sts_t.
`timescale 1ns / 1ps

module fbsp_ctrl
  import fbsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  fbsp_sts_t   sts,
  output fbsp_cmd_t   cmd
);

  fbsp_state_t state_r, state_nxt;
  logic        acc;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HEAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Bytes are taken only in the parse phases
  always_comb begin
    case (state_r) inside
      S_HEAD, S_LEN, S_DATA, S_SUM, S_END: in_ready = 1'b1;
      default:                             in_ready = 1'b0;
    endcase
  end

  assign acc = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HEAD: begin
        if (acc && sts.is_head) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (acc) begin
          if (sts.len_ok) begin
            cmd.load_len = 1'b1;
            state_nxt    = S_DATA;
          end else begin
            cmd.clr   = 1'b1;
            state_nxt = sts.is_head ? S_LEN : S_HEAD;
          end
        end
      end
      S_DATA: begin
        if (acc) begin
          cmd.store_byte = 1'b1;
          if (sts.data_done) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (acc) begin
          if (sts.sum_ok) begin
            state_nxt = S_END;
          end else begin
            cmd.clr   = 1'b1;
            state_nxt = sts.is_head ? S_LEN : S_HEAD;
          end
        end
      end
      S_END: begin
        if (acc) begin
          if (sts.is_end) begin
            cmd.drain_start = 1'b1;
            state_nxt       = S_DRAIN_RD;
          end else begin
            cmd.clr   = 1'b1;
            state_nxt = sts.is_head ? S_LEN : S_HEAD;
          end
        end
      end
      S_DRAIN_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_DRAIN_LD;
      end
      S_DRAIN_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.drain_last) begin
            cmd.clr   = 1'b1;
            state_nxt = S_HEAD;
          end else begin
            state_nxt = S_DRAIN_RD;
          end
        end
      end
      default: begin
        cmd.clr   = 1'b1;
        state_nxt = S_HEAD;
      end
    endcase
  end

endmodule

@@ hdl/fbsp_dp.sv @@
// Datapath of the framed byte stream parser: length, count, checksum,
// payload store and output register. Depends on fbsp_pkg and fbsp_ram.
`timescale 1ns / 1ps

module fbsp_dp
  import fbsp_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  fbsp_cmd_t         cmd,
  output fbsp_sts_t         sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic [POS_W-1:0]  out_byte_position,
  output logic [FLEN_W-1:0] out_frame_length,
  output logic              out_last
);

  localparam int CNT_W  = $clog2(PAYLOAD_MAX + 1);
  localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(PAYLOAD_MAX);

  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [CNT_W:0]    cnt_inc;
  logic [BYTE_W-1:0] rd_data;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [FLEN_W-1:0] out_len_r;
  logic              out_last_r;

  assign cnt_inc = {1'b0, cnt_r} + (CNT_W + 1)'(1);

  // Status toward the controller
  always_comb begin
    sts.is_head    = (in_rx_byte == HEAD_BYTE);
    sts.is_end     = (in_rx_byte == END_BYTE);
    sts.len_ok     = (in_rx_byte != '0) && (in_rx_byte <= MAX_LEN);
    sts.sum_ok     = (in_rx_byte == sum_r);
    sts.data_done  = (cnt_inc >= {1'b0, len_r});
    sts.drain_last = (cnt_inc == {1'b0, len_r});
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Length, count and checksum updates
  always_comb begin
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (cmd.clr) begin
      len_nxt = '0;
      cnt_nxt = '0;
      sum_nxt = '0;
    end else if (cmd.load_len) begin
      len_nxt = in_rx_byte[CNT_W-1:0];
      cnt_nxt = '0;
      sum_nxt = in_rx_byte;
    end else if (cmd.drain_start) begin
      cnt_nxt = '0;
    end else if (cmd.store_byte) begin
      cnt_nxt = cnt_inc[CNT_W-1:0];
      sum_nxt = sum_r ^ in_rx_byte;
    end else if (cmd.out_load) begin
      cnt_nxt = cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Payload store, addressed by the count both when filling and draining
  fbsp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_MAX)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_rx_byte),
    .re    (cmd.rd_issue),
    .raddr (cnt_r[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= rd_data;
      out_pos_r  <= POS_W'(cnt_r);
      out_len_r  <= FLEN_W'(len_r);
      out_last_r <= sts.drain_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_byte_r;
  assign out_byte_position = out_pos_r;
  assign out_frame_length  = out_len_r;
  assign out_last          = out_last_r;

endmodule

@@ hdl/framed_byte_stream_parser.sv @@
// Top level of the framed byte stream parser: controller plus datapath.
// Depends on fbsp_pkg, fbsp_ctrl, fbsp_dp (and through it fbsp_ram).
`timescale 1ns / 1ps

// Finds frames of the form 0xAA, length L (1..PAYLOAD_MAX), L payload bytes,
// XOR checksum (L xor all payload bytes), 0x55 in a stream of received bytes,
// and publishes the payload of each valid frame as L results in order, the
// final one flagged by out_last. A bad length, checksum or end byte drops the
// frame; if that byte is 0xAA it starts a new frame. A received byte is taken
// whenever in_valid is high in a parse phase. After a valid end byte the input
// is held off while the payload is read back from the store: each payload byte
// is read, then loaded into the output register, and the load waits while the
// output register holds a result that out_ready has not taken.
module framed_byte_stream_parser
  import fbsp_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic [POS_W-1:0]  out_byte_position,
  output logic [FLEN_W-1:0] out_frame_length,
  output logic              out_last
);

  fbsp_cmd_t cmd;
  fbsp_sts_t sts;

  fbsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbsp_dp #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_byte_position (out_byte_position),
    .out_frame_length  (out_frame_length),
    .out_last          (out_last)
  );

`ifndef SYNTHESIS
  // No received byte is taken while the store is being read back
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_issue || cmd.out_load) |-> !in_ready)
    else $error("input accepted during payload drain");

  // A load always leaves a pending result
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // Result position stays inside the declared length
  a_pos_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (PAYLOAD_MAX <= 32)) |->
      ({1'b0, out_byte_position} < out_frame_length))
    else $error("byte position beyond frame length");

  // Last flag marks exactly the final position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (PAYLOAD_MAX <= 32)) |->
      (out_last == (({1'b0, out_byte_position} + 6'd1) == out_frame_length)))
    else $error("last flag does not match position");
`endif

endmodule
